// ----- hdl/vwb64_pkg.sv -----
// shared types, constants and the symbol alphabet of the base64 packer
package vwb64_pkg;

  localparam int MaxCodeWidth = 26;
  localparam int MinCodeWidth = 8;
  localparam int WidthW       = 5;
  localparam int AccW         = 31;
  localparam int CntW         = 5;
  localparam int SymW         = 6;
  localparam int CharW        = 7;
  localparam int CodeW        = 32;
  localparam int DataW        = 32;
  localparam int AddrW        = 3;

  localparam logic       FuncPack     = 1'b0;
  localparam logic       FuncFlush    = 1'b1;
  localparam logic       RegCodeWidth = 1'b0;
  localparam logic [WidthW-1:0] WidthReset = WidthW'(MinCodeWidth);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HDR   = 5'b00010,
    S_PACK  = 5'b00100,
    S_FLUSH = 5'b01000,
    S_ERR   = 5'b10000
  } state_e;

  // commands to the accumulator unit
  typedef struct packed {
    logic load;
    logic shift;
    logic clear;
  } acc_ctrl_t;

  // accumulator status back to the sequencer
  typedef struct packed {
    logic [SymW-1:0] sym;
    logic [CntW-1:0] bits;
  } acc_stat_t;

  function automatic logic [CharW-1:0] sym_char(input logic [SymW-1:0] v);
    logic [CharW-1:0] c;
    if (v < 6'd10) begin
      c = 7'h30 + CharW'(v);
    end else if (v < 6'd36) begin
      c = 7'h41 + CharW'(v - 6'd10);
    end else if (v < 6'd62) begin
      c = 7'h61 + CharW'(v - 6'd36);
    end else if (v == 6'd62) begin
      c = 7'h2d;
    end else begin
      c = 7'h5f;
    end
    return c;
  endfunction

  function automatic logic [WidthW-1:0] clamp_width(input logic [WidthW-1:0] w);
    logic [WidthW-1:0] r;
    if (w < WidthW'(MinCodeWidth)) begin
      r = WidthW'(MinCodeWidth);
    end else if (w > WidthW'(MaxCodeWidth)) begin
      r = WidthW'(MaxCodeWidth);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

// ----- hdl/vwb64_acc.sv -----
// bit accumulator with the shared 6-bit shift unit
module vwb64_acc (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  vwb64_pkg::acc_ctrl_t                  ctrl_i,
  input  logic [vwb64_pkg::WidthW-1:0]          width_i,
  input  logic [vwb64_pkg::MaxCodeWidth-1:0]    raw_i,
  output vwb64_pkg::acc_stat_t                  stat_o
);
  import vwb64_pkg::*;

  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] bits_q, bits_d;

  always_comb begin
    acc_d  = acc_q;
    bits_d = bits_q;
    if (ctrl_i.clear) begin
      acc_d  = '0;
      bits_d = '0;
    end else if (ctrl_i.load) begin
      // pending bits are below six, so a small shift places the new code
      acc_d  = acc_q | (AccW'(raw_i) << bits_q[2:0]);
      bits_d = bits_q + CntW'(width_i);
    end else if (ctrl_i.shift) begin
      acc_d  = acc_q >> SymW;
      bits_d = bits_q - CntW'(SymW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      bits_q <= '0;
    end else begin
      acc_q  <= acc_d;
      bits_q <= bits_d;
    end
  end

  assign stat_o.sym  = acc_q[SymW-1:0];
  assign stat_o.bits = bits_q;

endmodule

// ----- hdl/variable_width_base64_packer_core.sv -----
// top level of the variable-width base64 packer
//
// usage
//   input channel: func_i and code_value_i move on a transfer (in_valid_i high,
//   in_stall_o low). func 0 packs a positive code lsb first, func 1 flushes
//   the partial group and closes the run. codes of zero or below add nothing.
//   output channel: one character per transfer on char_code_o with
//   char_valid_o, is_last_o and error_o; out_stall_i holds the result.
//   code_width sits at apb address 0, clamped to 8..26 on write.
// timing
//   an item is taken on a transfer, then the sequencer drives one result per
//   cycle while the output is not stalled, through the shared 6-bit shift
//   unit: optional width header, then up to five characters for a pack.
//   in_stall_o stays high until the last result is written to the output
//   register. the first result is written to the output register from the
//   sequencer state entered at the accept (S_HDR, S_PACK, S_FLUSH or S_ERR).
// reset
//   clears the accumulator, the header flag and the output valid; code_width
//   returns to 8.
// stall
//   a held result stops the sequencer from writing a new result; nothing is dropped.
module variable_width_base64_packer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // apb configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vwb64_pkg::AddrW-1:0]         paddr,
  input  logic [vwb64_pkg::DataW-1:0]         pwdata,
  output logic [vwb64_pkg::DataW-1:0]         prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic signed [vwb64_pkg::CodeW-1:0]  code_value_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [vwb64_pkg::CharW-1:0]         char_code_o,
  output logic                                char_valid_o,
  output logic                                is_last_o,
  output logic                                error_o
);
  import vwb64_pkg::*;

  state_e            state_q, state_d;
  logic [WidthW-1:0] width_q;
  logic              hdr_sent_q, hdr_sent_d;
  logic              func_q, func_d;
  logic              pos_q, pos_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  char_q, char_d;
  logic              cval_q, cval_d;
  logic              last_q, last_d;
  logic              err_q, err_d;
  logic              emit;

  acc_ctrl_t         acc_ctrl;
  acc_stat_t         acc_stat;

  logic              in_xfer;
  logic              out_free;
  logic              positive;
  logic              too_large;
  logic [CodeW-1:0]  limit;
  logic              cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegCodeWidth);
  assign prdata = (paddr[2] == RegCodeWidth) ? DataW'(width_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
    end else if (cfg_wr) begin
      width_q <= clamp_width(pwdata[WidthW-1:0]);
    end
  end

  // item classification at accept
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign positive   = (code_value_i != '0) && !code_value_i[CodeW-1];
  assign limit      = CodeW'(1) << width_q;
  assign too_large  = positive && ($unsigned(code_value_i) >= limit);

  vwb64_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .width_i (width_q),
    .raw_i   (code_value_i[MaxCodeWidth-1:0]),
    .stat_o  (acc_stat)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    hdr_sent_d = hdr_sent_q;
    func_d     = func_q;
    pos_d      = pos_q;
    acc_ctrl   = '0;
    emit       = 1'b0;
    char_d     = '0;
    cval_d     = 1'b0;
    last_d     = 1'b0;
    err_d      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          func_d = func_i;
          pos_d  = positive;
          if (func_i == FuncPack && too_large) begin
            state_d = S_ERR;
          end else begin
            acc_ctrl.load = (func_i == FuncPack) && positive;
            if (!hdr_sent_q) begin
              state_d = S_HDR;
            end else if (func_i == FuncPack) begin
              state_d = positive ? S_PACK : S_IDLE;
            end else begin
              state_d = S_FLUSH;
            end
          end
        end
      end
      S_HDR: begin
        if (out_free) begin
          emit       = 1'b1;
          char_d     = sym_char(SymW'(width_q));
          cval_d     = 1'b1;
          hdr_sent_d = 1'b1;
          if (func_q == FuncFlush) begin
            if (acc_stat.bits == '0) begin
              // flush with nothing pending: the header closes the run
              last_d         = 1'b1;
              acc_ctrl.clear = 1'b1;
              hdr_sent_d     = 1'b0;
              state_d        = S_IDLE;
            end else begin
              state_d = S_FLUSH;
            end
          end else begin
            state_d = pos_q ? S_PACK : S_IDLE;
          end
        end
      end
      S_PACK: begin
        if (out_free) begin
          emit           = 1'b1;
          char_d         = sym_char(acc_stat.sym);
          cval_d         = 1'b1;
          acc_ctrl.shift = 1'b1;
          if (acc_stat.bits < CntW'(2 * SymW)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          // partial group, or an empty marker when nothing is pending
          emit           = 1'b1;
          cval_d         = (acc_stat.bits != '0);
          char_d         = cval_d ? sym_char(acc_stat.sym) : '0;
          last_d         = 1'b1;
          acc_ctrl.clear = 1'b1;
          hdr_sent_d     = 1'b0;
          state_d        = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          emit           = 1'b1;
          last_d         = 1'b1;
          err_d          = 1'b1;
          acc_ctrl.clear = 1'b1;
          hdr_sent_d     = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hdr_sent_q  <= 1'b0;
      func_q      <= FuncPack;
      pos_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hdr_sent_q  <= hdr_sent_d;
      func_q      <= func_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only when a new result is written
  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= char_d;
      cval_q <= cval_d;
      last_q <= last_d;
      err_q  <= err_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_code_o  = char_q;
  assign char_valid_o = cval_q;
  assign is_last_o    = last_q;
  assign error_o      = err_q;

  // an error result carries no character and always ends the run
  a_err_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> is_last_o && !char_valid_o)
    else $error("error result without last or with a character");

  // between items fewer than one full symbol may be pending
  a_idle_bits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> acc_stat.bits < CntW'(SymW))
    else $error("full symbol left in accumulator");

  // no bits can be pending before the header of a run went out
  a_hdr_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && !hdr_sent_q |-> acc_stat.bits == '0)
    else $error("pending bits without header");

  // a new result is never written over one that is still stalled
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !emit)
    else $error("stalled result overwritten");

endmodule

// ----- tb/vwb64_result_checker.sv -----
// checker for the base64 packer: predicts the characters of each transfer and compares them
module vwb64_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vwb64_pkg::AddrW-1:0]     paddr,
  input  logic [vwb64_pkg::DataW-1:0]     pwdata,
  input  logic [vwb64_pkg::DataW-1:0]     prdata,
  input  logic                            pready,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            func_i,
  input  logic [vwb64_pkg::CodeW-1:0]     code_value_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [vwb64_pkg::CharW-1:0]     char_code_i,
  input  logic                            char_valid_i,
  input  logic                            is_last_i,
  input  logic                            error_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              chars_seen_o,
  output int                              errors_seen_o,
  output logic [vwb64_pkg::WidthW-1:0]    width_o
);
  import vwb64_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] glyph;
    logic             glyph_valid;
    logic             last;
    logic             err;
  } packer_result_t;

  // symbol 0 sits in the top byte
  localparam logic [64*8-1:0] Alphabet =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-_";

  logic [WidthW-1:0] width_q;
  logic [AccW-1:0]   acc_q;
  logic [2:0]        pend_q;
  logic              hdr_q;
  packer_result_t    expected_q[$];

  function automatic logic [CharW-1:0] glyph_of(input logic [SymW-1:0] sym);
    return Alphabet[(63 - int'(sym)) * 8 +: CharW];
  endfunction

  function automatic packer_result_t make_result(input logic [CharW-1:0] g, input logic v,
                                                 input logic l, input logic e);
    packer_result_t r;
    r.glyph       = g;
    r.glyph_valid = v;
    r.last        = l;
    r.err         = e;
    return r;
  endfunction

  task automatic note_failure(input string what);
    fail_count_o++;
    if (fail_count_o <= 10) $display("mismatch: %s", what);
  endtask

  task automatic predict_transfer(input logic f, input logic [CodeW-1:0] raw);
    packer_result_t batch[$];
    logic           positive;
    logic [63:0]    acc;
    int unsigned    bits;
    positive = (raw != '0) && !raw[CodeW-1];
    // oversized code aborts the run with a lone error result, no header
    if (f == FuncPack && positive && {32'd0, raw} >= (64'd1 << width_q)) begin
      expected_q = {expected_q, make_result('0, 1'b0, 1'b1, 1'b1)};
      acc_q  = '0;
      pend_q = '0;
      hdr_q  = 1'b0;
      return;
    end
    if (!hdr_q) begin
      batch = {batch, make_result(glyph_of(SymW'(width_q)), 1'b1, 1'b0, 1'b0)};
      hdr_q = 1'b1;
    end
    if (f == FuncPack) begin
      if (positive) begin
        acc  = {33'd0, acc_q} | ({32'd0, raw} << pend_q);
        bits = pend_q + width_q;
        while (bits >= SymW) begin
          batch = {batch, make_result(glyph_of(acc[SymW-1:0]), 1'b1, 1'b0, 1'b0)};
          acc  = acc >> SymW;
          bits = bits - SymW;
        end
        acc_q  = acc[AccW-1:0];
        pend_q = bits[2:0];
      end
    end else begin
      if (pend_q != '0) begin
        batch = {batch, make_result(glyph_of(acc_q[SymW-1:0]), 1'b1, 1'b1, 1'b0)};
      end else if (batch.size() > 0) begin
        batch[batch.size()-1].last = 1'b1;
      end else begin
        // empty flush
        batch = {batch, make_result('0, 1'b0, 1'b1, 1'b0)};
      end
      acc_q  = '0;
      pend_q = '0;
      hdr_q  = 1'b0;
    end
    expected_q = {expected_q, batch};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    packer_result_t seen;
    packer_result_t want;
    logic [WidthW-1:0] wr;
    if (!rst_ni) begin
      width_q       = WidthReset;
      acc_q         = '0;
      pend_q        = '0;
      hdr_q         = 1'b0;
      expected_q.delete();
      fail_count_o  = 0;
      chars_seen_o  = 0;
      errors_seen_o = 0;
      pending_o     = 0;
    end else begin
      // register port: writes are clamped, reads must echo the stored width
      if (psel && penable && pready && paddr[AddrW-1:2] == RegCodeWidth) begin
        if (pwrite) begin
          wr = pwdata[WidthW-1:0];
          if (wr < WidthW'(MinCodeWidth)) wr = WidthW'(MinCodeWidth);
          if (wr > WidthW'(MaxCodeWidth)) wr = WidthW'(MaxCodeWidth);
          width_q = wr;
        end else if (prdata !== DataW'(width_q)) begin
          note_failure($sformatf("code_width read %0d, want %0d", prdata, width_q));
        end
      end
      // results first: a transfer accepted now cannot answer in the same cycle
      if (out_valid_i && !out_stall_i) begin
        chars_seen_o++;
        if (error_i) errors_seen_o++;
        seen = make_result(char_code_i, char_valid_i, is_last_i, error_i);
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected result char=%h valid=%b last=%b err=%b",
                                 char_code_i, char_valid_i, is_last_i, error_i));
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            note_failure($sformatf(
              "want char=%h valid=%b last=%b err=%b, got char=%h valid=%b last=%b err=%b",
              want.glyph, want.glyph_valid, want.last, want.err,
              char_code_i, char_valid_i, is_last_i, error_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_transfer(func_i, code_value_i);
      pending_o = expected_q.size();
    end
  end

  assign width_o = width_q;

endmodule

// ----- tb/variable_width_base64_packer_core_tb.sv -----
// testbench top for the base64 packer: drives stimulus and gives the verdict
module variable_width_base64_packer_core_tb;
  import vwb64_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int RandomItems  = 460;
  localparam int RandomPhases = 8;
  localparam int SettleCycles = 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // register port
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // code channel
  logic             in_valid   = 1'b0;
  logic             in_stall;
  logic             func       = FuncPack;
  logic [CodeW-1:0] code_value = '0;

  // character channel
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CharW-1:0] char_code;
  logic             char_valid;
  logic             is_last;
  logic             code_error;

  int               fail_count;
  int               pending;
  int               chars_seen;
  int               errors_seen;
  logic [WidthW-1:0] cur_width;

  int          cycle_count = 0;
  int          items_sent  = 0;
  int          burst_left  = 0;
  bit          gaps_on     = 1'b1;
  logic [31:0] widths_hit  = '0;

  always #1 clk = ~clk;

  variable_width_base64_packer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .func_i      (func),
    .code_value_i(code_value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .char_code_o (char_code),
    .char_valid_o(char_valid),
    .is_last_o   (is_last),
    .error_o     (code_error)
  );

  vwb64_result_checker checker_u (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .func_i       (func),
    .code_value_i (code_value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .char_code_i  (char_code),
    .char_valid_i (char_valid),
    .is_last_i    (is_last),
    .error_i      (code_error),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .chars_seen_o (chars_seen),
    .errors_seen_o(errors_seen),
    .width_o      (cur_width)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("variable_width_base64_packer_core_tb: errors");
      $finish;
    end
  end

  // receiver stall pattern: free flow, light, heavy and blocky stretches
  initial begin
    int mode;
    int span;
    int k;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall <= ((k % 12) < 6);
          end
        endcase
      end
    end
  end

  // one code transfer; the sender works in bursts, with idle gaps between when gaps_on is set
  task automatic send_item(input logic f, input logic [CodeW-1:0] code);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    func       <= f;
    code_value <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // hold off the sender until every predicted character has come out
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // register writes only with the block idle; skipped codes leave no trace, so settle too
  task automatic reg_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    drain();
    repeat (SettleCycles) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    widths_hit[cur_width] = 1'b1;
  endtask

  task automatic reg_read(input logic [AddrW-1:0] addr);
    @(negedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    paddr  <= addr;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // legal code at the current width, leaning on the edges
  function automatic logic [CodeW-1:0] fitting_code();
    logic [CodeW-1:0] top_code;
    top_code = (32'd1 << cur_width) - 32'd1;
    case ($urandom_range(0, 5))
      0: return 32'd1;
      1: return top_code;
      2: return 32'd1 << $urandom_range(0, cur_width - 1);
      default: return $urandom_range(1, top_code);
    endcase
  endfunction

  // code that overflows the current width
  function automatic logic [CodeW-1:0] oversized_code();
    longint unsigned lo;
    longint unsigned span;
    lo   = 64'd1 << cur_width;
    span = 64'h8000_0000 - lo;
    case ($urandom_range(0, 3))
      0: return lo[CodeW-1:0];
      1: return 32'h7FFF_FFFF;
      default: return CodeW'(lo + (longint'($urandom) % span));
    endcase
  endfunction

  // zero or negative, never packed
  function automatic logic [CodeW-1:0] skipped_code();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom | 32'h8000_0000;
    endcase
  endfunction

  // mostly well formed runs with random content, the rest noise and broken runs
  task automatic random_phase(input int count);
    int  n;
    int  words;
    int  choice;
    bit  paused;
    n      = 0;
    paused = 1'b0;
    while (n < count) begin
      choice = $urandom_range(0, 99);
      if (choice < 72) begin
        words = $urandom_range(1, 6);
        repeat (words) begin
          send_item(FuncPack, fitting_code());
          n++;
        end
        if ($urandom_range(0, 99) < 85) begin
          send_item(FuncFlush, $urandom);
          n++;
        end
      end else if (choice < 82) begin
        send_item(FuncPack, skipped_code());
        n++;
      end else if (choice < 91) begin
        send_item(FuncPack, oversized_code());
        n++;
      end else begin
        // flush in an odd place, payload is junk
        send_item(FuncFlush, $urandom);
        n++;
      end
      if (!paused && n >= count / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    logic [DataW-1:0] settings[RandomPhases];
    int               p;
    settings = '{32'd0, 32'd31, 32'd13, 32'hFFFF_FF17, 32'd7, 32'd27, 32'd8, 32'd26};
    settings[2] = $urandom;

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    widths_hit[WidthReset] = 1'b1;

    // directed at the reset width of 8
    send_item(FuncPack, 32'h8000_0000);   // skipped code still opens the run with the header
    send_item(FuncPack, 32'd1);
    send_item(FuncPack, 32'd255);
    send_item(FuncPack, 32'd0);
    send_item(FuncPack, 32'hFFFF_FFFF);
    send_item(FuncPack, 32'd256);         // overflow in the middle of a run
    send_item(FuncPack, 32'd300);         // overflow as the first item, no header
    send_item(FuncFlush, 32'd0);          // header alone carries the last flag
    send_item(FuncPack, 32'd255);
    send_item(FuncPack, 32'd170);
    send_item(FuncPack, 32'd85);          // 24 bits, nothing left over
    send_item(FuncFlush, 32'hFFFF_FFFF);  // flush with nothing pending
    send_item(FuncFlush, 32'd0);

    // directed at the widest setting
    reg_write('0, 32'd26);
    reg_read('0);
    send_item(FuncPack, 32'h03FF_FFFF);
    send_item(FuncPack, 32'h03FF_FFFF);
    send_item(FuncPack, 32'h03FF_FFFF);
    send_item(FuncPack, 32'h7FFF_FFFF);
    send_item(FuncPack, 32'h0400_0000);
    send_item(FuncPack, 32'h02AA_AAAA);
    send_item(FuncFlush, 32'd0);          // partial group on the last character
    send_item(FuncPack, 32'd1);
    send_item(FuncFlush, 32'd0);

    // write to an unmapped index must leave the width alone
    reg_write(AddrW'(4), $urandom);
    reg_read('0);
    reg_read(AddrW'(4));

    for (p = 0; p < RandomPhases; p++) begin
      reg_write('0, settings[p]);
      reg_read('0);
      gaps_on = ($urandom_range(0, 3) != 0);
      random_phase(RandomItems / RandomPhases);
    end

    drain();
    repeat (20) @(negedge clk);

    $display("covered %0d code transfers at %0d code widths with random gaps and stalls",
             items_sent, $countones(widths_hit));
    $display("checked %0d characters, %0d of them error results", chars_seen, errors_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("variable_width_base64_packer_core_tb: clean");
    end else begin
      $display("variable_width_base64_packer_core_tb: errors");
    end
    $finish;
  end

endmodule
